/* hw/rtl/via_pkg.sv */
package via_pkg;

  localparam int CW = 26;   // working width of offsets, extents and enclosures
  localparam int PW = 28;   // working width of exact corners
  localparam int NW = 14;   // signed cut count, may go well below zero
  localparam int DW = 17;   // magnitude of the per-axis dividend
  localparam int SW = 11;   // cut pitch, width plus spacing
  localparam int IW = 3;    // cut index, enough for the largest cut count
  localparam int IXW = 3;   // configuration register index
  localparam int CFG_DW = 60;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] count_t;

  typedef struct packed {
    logic [11:0]        net;
    logic [7:0]         cut_layer;
    logic [7:0]         down_layer;
    logic [7:0]         up_layer;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               flip_x;
    logic               flip_y;
    coord_t             off_x;
    coord_t             off_y;
    coord_t             wid_x;
    coord_t             wid_y;
    count_t             num_x;
    count_t             num_y;
    coord_t             dn_x;
    coord_t             dn_y;
    coord_t             up_x;
    coord_t             up_y;
    logic [9:0]         cut_w;
    logic [SW-1:0]      pitch;
  } via_job_t;

  // Exact corner: origin plus a distance taken in the axis direction.
  function automatic logic signed [PW-1:0] via_pt(logic signed [23:0] p, coord_t d,
                                                  logic flip);
    logic signed [PW-1:0] dd;
    dd = PW'(d);
    via_pt = PW'(p) + (flip ? -dd : dd);
  endfunction

endpackage

/* hw/rtl/via_if.sv */
interface via_req_if;
  logic               valid;
  logic               ready;
  logic [11:0]        net_id;
  logic [1:0]         via_level;
  logic [15:0]        size_x;
  logic [15:0]        size_y;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic               flip_x;
  logic               flip_y;
  modport source(output valid, net_id, via_level, size_x, size_y, origin_x, origin_y,
                 flip_x, flip_y, input ready);
  modport sink(input valid, net_id, via_level, size_x, size_y, origin_x, origin_y,
               flip_x, flip_y, output ready);
endinterface

interface via_rect_if;
  logic               valid;
  logic               ready;
  logic [7:0]         layer_id;
  logic [11:0]        rect_net;
  logic signed [23:0] left_edge;
  logic signed [23:0] bottom_edge;
  logic signed [23:0] right_edge;
  logic signed [23:0] top_edge;
  logic               last_rect;
  modport source(output valid, layer_id, rect_net, left_edge, bottom_edge, right_edge,
                 top_edge, last_rect, input ready);
  modport sink(input valid, layer_id, rect_net, left_edge, bottom_edge, right_edge,
               top_edge, last_rect, output ready);
endinterface

/* hw/rtl/via_front.sv */
module via_front import via_pkg::*; #(
  parameter int MAX_CUTS_PER_AXIS = 7,
  parameter int VIA_LEVELS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IXW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  via_req_if.sink          req,
  output logic             push,
  output via_job_t         job,
  input  logic             full
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_NUM  = 6'b000100,
    S_WID  = 6'b001000,
    S_OFF  = 6'b010000,
    S_PUSH = 6'b100000
  } fstate_t;

  fstate_t state, state_next;

  logic [23:0] layers [VIA_LEVELS];
  logic [59:0] rules  [VIA_LEVELS];

  logic [11:0]        net;
  logic               lvl0;
  logic [15:0]        size [2];
  logic signed [23:0] pos  [2];
  logic               flip [2];
  logic [7:0]         cut_l, down_l, up_l;
  logic [9:0]         w, s, dnlo, dnhi, uplo, uphi;
  logic               zstep;
  logic [DW-1:0]      dvd [2];
  logic [SW-1:0]      rem [2];
  logic               neg [2];
  logic [4:0]         dcnt;
  count_t             num [2];
  coord_t             wid [2];

  logic [23:0]   sel_lay;
  logic [59:0]   sel_rul;
  logic [SW-1:0] step;
  logic          take;

  assign step = SW'(w) + SW'(s);
  assign req.ready = (state == S_IDLE);
  assign take = req.valid && req.ready;
  assign push = (state == S_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < VIA_LEVELS; l++) begin
        layers[l] <= '0;
        rules[l]  <= '0;
      end
    end else if (cfg_we) begin
      for (int l = 0; l < VIA_LEVELS; l++) begin
        if (cfg_index == IXW'(2 * l)) layers[l] <= cfg_data[23:0];
        if (cfg_index == IXW'(2 * l + 1)) rules[l] <= cfg_data[59:0];
      end
    end
  end

  always_comb begin
    sel_lay = '0;
    sel_rul = '0;
    for (int l = 0; l < VIA_LEVELS; l++) begin
      if (req.via_level == 2'(l)) begin
        sel_lay = layers[l];
        sel_rul = rules[l];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (take && 32'(req.via_level) < VIA_LEVELS) state_next = S_DIV;
      S_DIV:  if (dcnt == 5'(DW - 1)) state_next = S_NUM;
      S_NUM:  state_next = S_WID;
      S_WID:  state_next = S_OFF;
      S_OFF:  state_next = S_PUSH;
      S_PUSH: if (!full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath
  logic signed [18:0] numer [2];
  logic [SW:0]        trial [2];
  logic [DW-1:0]      qmag [2];
  count_t             num_next [2];
  coord_t             wid_next [2];
  coord_t             off_n [2];
  coord_t             diff [2];
  coord_t             nm, st, sv;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      numer[a] = 19'($signed({3'b0, (a == 0) ? req.size_x : req.size_y}))
               - 19'($signed({9'b0, sel_rul[9:0]}))
               - 19'($signed({8'b0, sel_rul[29:20], 1'b0}));
      trial[a] = {rem[a], dvd[a][DW-1]};
      qmag[a]  = zstep ? '0 : dvd[a];
      if (!neg[a]) begin
        if (qmag[a] >= DW'(MAX_CUTS_PER_AXIS)) num_next[a] = NW'(MAX_CUTS_PER_AXIS);
        else num_next[a] = NW'(qmag[a]) + NW'(1);
      end else begin
        num_next[a] = NW'(1) - NW'(qmag[a]);
      end
      nm = CW'(num[a]);
      st = CW'($signed({1'b0, step}));
      sv = CW'($signed({1'b0, s}));
      wid_next[a] = nm * st - sv;
      diff[a] = CW'($signed({1'b0, size[a]})) - wid[a];
      off_n[a] = (diff[a] > 0) ? (diff[a] >>> 1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          dcnt <= '0;
          if (take) begin
            net  <= req.net_id;
            lvl0 <= (req.via_level == 2'd0);
            size[0] <= req.size_x;
            size[1] <= req.size_y;
            pos[0]  <= req.origin_x;
            pos[1]  <= req.origin_y;
            flip[0] <= req.flip_x;
            flip[1] <= req.flip_y;
            cut_l  <= sel_lay[7:0];
            down_l <= sel_lay[15:8];
            up_l   <= sel_lay[23:16];
            w    <= sel_rul[9:0];
            s    <= sel_rul[19:10];
            dnlo <= sel_rul[29:20];
            dnhi <= sel_rul[39:30];
            uplo <= sel_rul[49:40];
            uphi <= sel_rul[59:50];
            zstep <= (sel_rul[19:0] == '0);
            for (int a = 0; a < 2; a++) begin
              neg[a] <= numer[a][18];
              dvd[a] <= numer[a][18] ? DW'(-numer[a]) : DW'(numer[a]);
              rem[a] <= '0;
            end
          end
        end
        S_DIV: begin
          dcnt <= dcnt + 5'd1;
          for (int a = 0; a < 2; a++) begin
            if (trial[a] >= {1'b0, step}) begin
              rem[a] <= SW'(trial[a] - {1'b0, step});
              dvd[a] <= {dvd[a][DW-2:0], 1'b1};
            end else begin
              rem[a] <= trial[a][SW-1:0];
              dvd[a] <= {dvd[a][DW-2:0], 1'b0};
            end
          end
        end
        S_NUM: for (int a = 0; a < 2; a++) num[a] <= num_next[a];
        S_WID: for (int a = 0; a < 2; a++) wid[a] <= wid_next[a];
        S_OFF: begin
          job.net        <= net;
          job.cut_layer  <= cut_l;
          job.down_layer <= down_l;
          job.up_layer   <= up_l;
          job.pos_x  <= pos[0];
          job.pos_y  <= pos[1];
          job.flip_x <= flip[0];
          job.flip_y <= flip[1];
          job.off_x  <= off_n[0];
          job.off_y  <= off_n[1];
          job.wid_x  <= wid[0];
          job.wid_y  <= wid[1];
          job.num_x  <= num[0];
          job.num_y  <= num[1];
          job.cut_w  <= w;
          job.pitch  <= step;
          if (off_n[0] < CW'($signed({1'b0, dnhi}))) begin
            job.dn_x <= CW'($signed({1'b0, dnhi}));
            job.dn_y <= lvl0 ? off_n[1] : CW'($signed({1'b0, dnlo}));
          end else begin
            job.dn_x <= CW'($signed({1'b0, dnlo}));
            job.dn_y <= lvl0 ? off_n[1] : CW'($signed({1'b0, dnhi}));
          end
          if (off_n[0] < CW'($signed({1'b0, uphi}))) begin
            job.up_x <= CW'($signed({1'b0, uphi}));
            job.up_y <= CW'($signed({1'b0, uplo}));
          end else begin
            job.up_x <= CW'($signed({1'b0, uplo}));
            job.up_y <= CW'($signed({1'b0, uphi}));
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/via_queue.sv */
module via_queue import via_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  via_job_t wr_job,
  output logic     full,
  input  logic     pop,
  output via_job_t rd_job,
  output logic     empty
);

  via_job_t   slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full   = (cnt == 2'd2);
  assign empty  = (cnt == 2'd0);
  assign rd_job = slot[rp];

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/via_back.sv */
module via_back import via_pkg::*; #(
  parameter int MAX_CUTS_PER_AXIS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  via_job_t   rd_job,
  output logic       pop,
  via_rect_if.source rect
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOWER = 4'b0010,
    S_CUTS  = 4'b0100,
    S_UPPER = 4'b1000
  } bstate_t;

  bstate_t  state;
  via_job_t jb;
  coord_t   cx, cy;
  logic [IW-1:0] ci, cj;

  logic   room;
  logic   emit;
  coord_t a0x, a1x, a0y, a1y;
  logic [7:0] lay;
  logic signed [PW-1:0] x0, x1, y0, y1;
  logic   col_end, row_end;

  assign room = !rect.valid || rect.ready;
  assign emit = (state != S_IDLE) && room;
  assign pop  = (state == S_IDLE) && !empty;
  assign col_end = (NW'(cj) == jb.num_y - NW'(1));
  assign row_end = (NW'(ci) == jb.num_x - NW'(1));

  always_comb begin
    case (state)
      S_LOWER: begin
        a0x = jb.off_x - jb.dn_x;
        a1x = jb.off_x + jb.wid_x + jb.dn_x;
        a0y = jb.off_y - jb.dn_y;
        a1y = jb.off_y + jb.wid_y + jb.dn_y;
        lay = jb.down_layer;
      end
      S_CUTS: begin
        a0x = cx;
        a1x = cx + CW'($signed({1'b0, jb.cut_w}));
        a0y = cy;
        a1y = cy + CW'($signed({1'b0, jb.cut_w}));
        lay = jb.cut_layer;
      end
      default: begin
        a0x = jb.off_x - jb.up_x;
        a1x = jb.off_x + jb.wid_x + jb.up_x;
        a0y = jb.off_y - jb.up_y;
        a1y = jb.off_y + jb.wid_y + jb.up_y;
        lay = jb.up_layer;
      end
    endcase
    x0 = via_pt(jb.pos_x, a0x, jb.flip_x);
    x1 = via_pt(jb.pos_x, a1x, jb.flip_x);
    y0 = via_pt(jb.pos_y, a0y, jb.flip_y);
    y1 = via_pt(jb.pos_y, a1y, jb.flip_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rect.valid <= 1'b0;
    end else begin
      // Hold a refused item, drop a taken one, raise on a new one
      rect.valid <= emit || (rect.valid && !rect.ready);
      case (state)
        S_IDLE: if (!empty) begin
          jb <= rd_job;
          state <= S_LOWER;
        end
        S_LOWER: if (room) begin
          cx <= jb.off_x;
          cy <= jb.off_y;
          ci <= '0;
          cj <= '0;
          state <= (jb.num_x > 0 && jb.num_y > 0) ? S_CUTS : S_UPPER;
        end
        S_CUTS: if (room) begin
          if (col_end) begin
            cj <= '0;
            cy <= jb.off_y;
            if (row_end) state <= S_UPPER;
            else begin
              ci <= ci + IW'(1);
              cx <= cx + CW'($signed({1'b0, jb.pitch}));
            end
          end else begin
            cj <= cj + IW'(1);
            cy <= cy + CW'($signed({1'b0, jb.pitch}));
          end
        end
        S_UPPER: if (room) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output payload: normalize corners, then wrap to 24 bits
  always_ff @(posedge clk) begin
    if (emit) begin
      rect.layer_id    <= lay;
      rect.rect_net    <= jb.net;
      rect.left_edge   <= (x1 < x0) ? x1[23:0] : x0[23:0];
      rect.right_edge  <= (x1 < x0) ? x0[23:0] : x1[23:0];
      rect.bottom_edge <= (y1 < y0) ? y1[23:0] : y0[23:0];
      rect.top_edge    <= (y1 < y0) ? y0[23:0] : y1[23:0];
      rect.last_rect   <= (state == S_UPPER);
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE) else $error("job taken while busy");
  a_cuts_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_CUTS |-> jb.num_x > 0 && jb.num_y > 0) else $error("cut with no cuts");
  a_cut_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CUTS |-> 32'(ci) < MAX_CUTS_PER_AXIS && 32'(cj) < MAX_CUTS_PER_AXIS)
    else $error("cut index out of range");

endmodule

/* hw/rtl/via_array_generator.sv */
// Via array generator.
// A request enters on req (valid/ready); each result rectangle leaves on rect
// (valid/ready). An item is taken at a clock edge where valid and ready are both high.
// Registers are written through cfg_we/cfg_index/cfg_data, index 2L for the layers
// and 2L+1 for the rules of level L; write only while the block is idle.
// The front takes a request, divides both axes at once in a bit-serial divider,
// then works out cut count, array extent, and centring offset with enclosure swaps
// in turn, and finally hands the job to a two-entry queue.
// The front accepts its next request as soon as the job is queued, and takes no
// new request before then.
// The back emits one rectangle per cycle while the receiver keeps up: lower layer,
// cuts with x outer and y inner, then upper layer with last_rect set; it fetches
// each job from the queue while idle. A request with an unknown level gives no
// rectangles and is dropped by the front.
// A stalled receiver holds the output register; the back then waits, the queue
// fills and the front holds req.ready low once it has a job it cannot queue.
// Synchronous reset clears the configuration registers to zero, empties the queue
// and returns both state machines to idle with no rectangle pending.
module via_array_generator import via_pkg::*; #(
  parameter int MAX_CUTS_PER_AXIS = 7,
  parameter int VIA_LEVELS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IXW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  via_req_if.sink           req,
  via_rect_if.source        rect
);

  via_job_t wr_job, rd_job;
  logic     push, full, pop, empty;

  // Accept, divide and classify
  via_front #(.MAX_CUTS_PER_AXIS(MAX_CUTS_PER_AXIS), .VIA_LEVELS(VIA_LEVELS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .req,
    .push, .job(wr_job), .full
  );

  // Decouple front and back
  via_queue u_queue (
    .clk, .rst, .push, .wr_job, .full, .pop, .rd_job, .empty
  );

  // Walk the rectangles of one job
  via_back #(.MAX_CUTS_PER_AXIS(MAX_CUTS_PER_AXIS)) u_back (
    .clk, .rst, .empty, .rd_job, .pop, .rect
  );

endmodule

/* sim/via_array_generator_test.sv */
module via_array_generator_test;
  import via_pkg::*;

  localparam int MAX_CUTS = 7;
  localparam int LEVELS = 3;
  localparam int CYCLE_LIMIT = 400000;

  // Register indexes: layers of level L at 2L, rules at 2L+1.
  typedef enum logic [IXW-1:0] {
    REG_LAYERS0 = 3'd0, REG_RULES0 = 3'd1,
    REG_LAYERS1 = 3'd2, REG_RULES1 = 3'd3,
    REG_LAYERS2 = 3'd4, REG_RULES2 = 3'd5,
    REG_SPARE6  = 3'd6, REG_SPARE7 = 3'd7
  } reg_index_e;

  typedef struct packed {
    logic [7:0]         layer;
    logic [11:0]        net;
    logic signed [23:0] left;
    logic signed [23:0] bottom;
    logic signed [23:0] right;
    logic signed [23:0] top;
    logic               last;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IXW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  via_req_if req ();
  via_rect_if rect ();

  via_array_generator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rect(rect.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the layer and rule registers.
  logic [23:0] layer_regs [LEVELS];
  logic [59:0] rule_regs [LEVELS];

  rect_t rect_queue [$];
  int errors = 0;
  int cycles = 0;
  bit quiet_sender = 1'b0;   // no idling on the request side
  bit quiet_receiver = 1'b0; // no stalls on the result side
  int hold_off = 0;          // cycles the receiver refuses outright

  // Normalise corners, then wrap to 24 bits, and queue the rectangle.
  function automatic void queue_rect(logic [7:0] lay, logic [11:0] net,
                                     longint x0, longint y0, longint x1, longint y1,
                                     logic last);
    longint t;
    rect_t r;
    if (x1 < x0) begin t = x0; x0 = x1; x1 = t; end
    if (y1 < y0) begin t = y0; y0 = y1; y1 = t; end
    r.layer = lay;
    r.net = net;
    r.left = x0[23:0];
    r.bottom = y0[23:0];
    r.right = x1[23:0];
    r.top = y1[23:0];
    r.last = last;
    rect_queue = {rect_queue, r};
  endfunction

  // Work out every rectangle a request produces.
  function automatic void expand_via(logic [11:0] net, logic [1:0] lvl,
                                     logic [15:0] sx, logic [15:0] sy,
                                     logic signed [23:0] ox, logic signed [23:0] oy,
                                     logic fx, logic fy);
    longint sz [2], org [2], dir [2], num [2], ext [2], off [2];
    longint dn [2], up [2], w, s, pitch, q, t, cx, cy;
    logic [59:0] r;
    logic [23:0] lay;
    if (lvl >= LEVELS) return;
    sz[0] = sx; sz[1] = sy;
    org[0] = ox; org[1] = oy;
    dir[0] = fx ? -1 : 1;
    dir[1] = fy ? -1 : 1;
    lay = layer_regs[lvl];
    r = rule_regs[lvl];
    w = r[9:0]; s = r[19:10];
    dn[0] = r[29:20]; dn[1] = r[39:30];
    up[0] = r[49:40]; up[1] = r[59:50];
    pitch = w + s;
    for (int a = 0; a < 2; a++) begin
      q = 0;
      if (pitch != 0) q = (sz[a] - w - 2 * dn[0]) / pitch;
      num[a] = 1 + q;
      if (num[a] > MAX_CUTS) num[a] = MAX_CUTS;
      ext[a] = num[a] * w + (num[a] - 1) * s;
      off[a] = (sz[a] > ext[a]) ? (sz[a] - ext[a]) / 2 : 0;
    end
    if (off[0] < dn[1]) begin t = dn[0]; dn[0] = dn[1]; dn[1] = t; end
    if (off[0] < up[1]) begin t = up[0]; up[0] = up[1]; up[1] = t; end
    if (lvl == 0) dn[1] = off[1];
    queue_rect(lay[15:8], net,
               org[0] + (off[0] - dn[0]) * dir[0], org[1] + (off[1] - dn[1]) * dir[1],
               org[0] + (off[0] + ext[0] + dn[0]) * dir[0],
               org[1] + (off[1] + ext[1] + dn[1]) * dir[1], 1'b0);
    for (longint i = 0; i < num[0]; i++)
      for (longint j = 0; j < num[1]; j++) begin
        cx = off[0] + i * pitch;
        cy = off[1] + j * pitch;
        queue_rect(lay[7:0], net, org[0] + cx * dir[0], org[1] + cy * dir[1],
                   org[0] + (cx + w) * dir[0], org[1] + (cy + w) * dir[1], 1'b0);
      end
    queue_rect(lay[23:16], net,
               org[0] + (off[0] - up[0]) * dir[0], org[1] + (off[1] - up[1]) * dir[1],
               org[0] + (off[0] + ext[0] + up[0]) * dir[0],
               org[1] + (off[1] + ext[1] + up[1]) * dir[1], 1'b1);
  endfunction

  // Cycle counter doubles as the watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, compare each item taken.
  always @(posedge clk) begin
    if (rst) begin
      rect.ready <= 1'b0;
    end else begin
      if (rect.valid && rect.ready) begin
        if (rect_queue.size() == 0) begin
          $error("unexpected rectangle layer %0d net %0d", rect.layer_id, rect.rect_net);
          errors++;
        end else begin
          rect_t e;
          e = rect_queue.pop_front();
          if (rect.layer_id !== e.layer) begin
            $error("layer_id expected %0d got %0d", e.layer, rect.layer_id); errors++;
          end
          if (rect.rect_net !== e.net) begin
            $error("rect_net expected %0d got %0d", e.net, rect.rect_net); errors++;
          end
          if (rect.left_edge !== e.left) begin
            $error("left_edge expected %0d got %0d", e.left, rect.left_edge); errors++;
          end
          if (rect.bottom_edge !== e.bottom) begin
            $error("bottom_edge expected %0d got %0d", e.bottom, rect.bottom_edge); errors++;
          end
          if (rect.right_edge !== e.right) begin
            $error("right_edge expected %0d got %0d", e.right, rect.right_edge); errors++;
          end
          if (rect.top_edge !== e.top) begin
            $error("top_edge expected %0d got %0d", e.top, rect.top_edge); errors++;
          end
          if (rect.last_rect !== e.last) begin
            $error("last_rect expected %0d got %0d", e.last, rect.last_rect); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rect.ready <= 1'b0;
      end else begin
        rect.ready <= quiet_receiver || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.net_id = '0;
    req.via_level = '0;
    req.size_x = '0;
    req.size_y = '0;
    req.origin_x = '0;
    req.origin_y = '0;
    req.flip_x = 1'b0;
    req.flip_y = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      layer_regs[l] = '0;
      rule_regs[l] = '0;
    end
  end

  // Write one register; only called while the block is idle.
  task automatic write_reg(reg_index_e idx, logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_RULES2) begin
      if (idx[0]) rule_regs[idx >> 1] = value;
      else layer_regs[idx >> 1] = value[23:0];
    end
  endtask

  function automatic logic [59:0] pack_rules(int w, int s, int dlo, int dhi,
                                             int ulo, int uhi);
    return {10'(uhi), 10'(ulo), 10'(dhi), 10'(dlo), 10'(s), 10'(w)};
  endfunction

  // Send one request; predict on acceptance, drop valid for a cycle after.
  task automatic send_via(logic [11:0] net, logic [1:0] lvl, logic [15:0] sx,
                          logic [15:0] sy, logic [23:0] ox, logic [23:0] oy,
                          logic fx, logic fy);
    while (!quiet_sender && $urandom_range(99) < 22) @(posedge clk);
    req.valid <= 1'b1;
    req.net_id <= net;
    req.via_level <= lvl;
    req.size_x <= sx;
    req.size_y <= sy;
    req.origin_x <= ox;
    req.origin_y <= oy;
    req.flip_x <= fx;
    req.flip_y <= fy;
    do @(posedge clk); while (!req.ready);
    expand_via(net, lvl, sx, sy, ox, oy, fx, fy);
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every rectangle is in, then let the pipeline drain.
  task automatic drain;
    while (rect_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Mostly small sizes so cut counts stay in range; some full scale.
  task automatic send_random(int count);
    logic [15:0] sx, sy;
    for (int n = 0; n < count; n++) begin
      sx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
      sy = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
      send_via(12'($urandom), ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2)),
               sx, sy, 24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic randomise_rules;
    for (int l = 0; l < LEVELS; l++) begin
      write_reg(reg_index_e'(2 * l), CFG_DW'($urandom));
      write_reg(reg_index_e'(2 * l + 1),
                pack_rules($urandom_range(40), $urandom_range(40), $urandom_range(30),
                           $urandom_range(30), $urandom_range(30), $urandom_range(30)));
    end
  endtask

  // Zero registers after reset: zero pitch, one cut each way.
  task automatic test_reset_rules;
    send_via(12'hFFF, 2'd0, 16'd100, 16'd50, 24'h000000, 24'h000000, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_directed;
    write_reg(REG_LAYERS0, 60'hABCDEF);
    write_reg(REG_RULES0, pack_rules(10, 5, 3, 8, 2, 6));
    write_reg(REG_LAYERS1, 60'hFFFFFF);
    write_reg(REG_RULES1, pack_rules(1, 0, 0, 0, 0, 0));   // cuts saturate
    write_reg(REG_LAYERS2, 60'h010203);
    write_reg(REG_RULES2, pack_rules(1023, 1023, 1023, 1023, 1023, 1023));
    write_reg(REG_SPARE6, '1);   // ignored
    write_reg(REG_SPARE7, '1);
    send_via(12'h000, 2'd0, 16'd60, 16'd60, 24'h000100, 24'h000200, 1'b0, 1'b0);
    send_via(12'h5A5, 2'd0, 16'd60, 16'd60, 24'h000100, 24'h000200, 1'b1, 1'b1);
    send_via(12'hA5A, 2'd1, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
    send_via(12'h123, 2'd2, 16'd10, 16'd0, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    send_via(12'h456, 2'd3, 16'd100, 16'd100, 24'h0, 24'h0, 1'b0, 1'b0);   // dropped
    send_via(12'hFFF, 2'd0, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'h000001, 1'b1, 1'b0);
    send_via(12'h001, 2'd1, 16'd0, 16'd0, 24'h7FFFF0, 24'h7FFFF0, 1'b0, 1'b0);
    send_via(12'h800, 2'd2, 16'hFFFF, 16'hFFFF, 24'h000000, 24'h000000, 1'b0, 1'b1);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering; queue fills and stalls.
  task automatic test_backpressure;
    write_reg(REG_RULES0, pack_rules(4, 2, 1, 1, 1, 1));
    write_reg(REG_RULES1, pack_rules(3, 3, 2, 4, 2, 4));
    hold_off = 400;
    send_random(8);
    drain();
  endtask

  task automatic test_random;
    randomise_rules();
    send_random(30);
    drain();
    // Sender pauses until everything is out, then goes flat out.
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    send_random(20);
    drain();
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    randomise_rules();
    send_random(45);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_rules();
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* via_array_generator.f */
hw/rtl/via_pkg.sv
hw/rtl/via_if.sv
hw/rtl/via_front.sv
hw/rtl/via_queue.sv
hw/rtl/via_back.sv
hw/rtl/via_array_generator.sv
sim/via_array_generator_test.sv
